// ===== design/bct_pkg.sv =====
// -----------------------------------------------------------------------------
// bct_pkg
// Shared types for the bucketed chain table: opcodes, status codes and the
// control bundle between the sequencer and the slot store.
// -----------------------------------------------------------------------------
package bct_pkg;

	// Field widths fixed by the request and response words
	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned KEYPORT_W = 64;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned STATUS_W  = 3;

	// Hardware home index reach (bucket_index is four bits wide)
	localparam int unsigned INDEX_REACH = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} bct_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 3'd0,
		ST_FOUND   = 3'd1,
		ST_MISSING = 3'd2,
		ST_DROPPED = 3'd3,
		ST_UNKNOWN = 3'd4
	} bct_status_t;

	// Strobes from sequencer to slot store
	typedef struct packed {
		logic rd;     // read key, payload and link at rd_addr
		logic kp_wr;  // write key and payload at kp_addr
		logic lk_wr;  // write link at lk_addr
	} bct_mem_ctl_t;

endpackage

// ===== design/bucketed_chain_table_unit.sv =====
// -----------------------------------------------------------------------------
// bucketed_chain_table_unit
// Hash table with fixed home buckets and an overflow pool on a free list.
// Insert, delete and search on a chain of slots; one status word per request.
// -----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   in_valid / in_stall   opcode, bucket_known, bucket_index,
//                                  entry_key, entry_payload
//  response  out_valid / out_stall status
//
// A request walks its chain one slot read at a time; the single read port
// of the slot RAMs sets that, one slot per cycle. Insert into a chain adds
// a free-list pop and node write (S_ALLOC); delete that unlinks or promotes
// adds a free-list push (S_FREE), a promote first copying the next node home.
// One request is worked at a time; the next is taken while a status word
// still waits in the output register.
// Reset is immediate: no clearing pass, the pool reads as a fresh free list.
// A stalled response holds the sequencer only when a second status is ready.
// -----------------------------------------------------------------------------
module bucketed_chain_table_unit #(
	parameter int unsigned POOL_SLOTS   = 64,
	parameter int unsigned HOME_BUCKETS = 16,
	parameter int unsigned KEY_BITS     = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bct_pkg::OPCODE_W-1:0]    opcode,
	input  logic                            bucket_known,
	input  logic [bct_pkg::INDEX_W-1:0]     bucket_index,
	input  logic [bct_pkg::KEYPORT_W-1:0]   entry_key,
	input  logic [bct_pkg::PAYLOAD_W-1:0]   entry_payload,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bct_pkg::STATUS_W-1:0]    status
);

	localparam int unsigned ADDR_W   = $clog2(POOL_SLOTS);
	localparam int unsigned LINK_W   = $clog2(POOL_SLOTS + 1);
	localparam int unsigned HOME_USE = (HOME_BUCKETS < bct_pkg::INDEX_REACH) ?
		HOME_BUCKETS : bct_pkg::INDEX_REACH;
	localparam int unsigned HU_W     = $clog2(HOME_USE);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ALLOC,
		S_TAIL,
		S_CMP,
		S_PROMOTE,
		S_FREE,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [HOME_USE-1:0]             used_q;
	logic [LINK_W-1:0]               free_head_q;
	logic                            out_valid_q;
	bct_pkg::bct_status_t            status_q;

	bct_pkg::bct_op_t                op_q;
	logic                            known_q;
	logic [bct_pkg::INDEX_W-1:0]     home_q;
	logic [KEY_BITS-1:0]             key_q;
	logic [bct_pkg::PAYLOAD_W-1:0]   pay_q;
	logic [ADDR_W-1:0]               cur_q;
	logic [ADDR_W-1:0]               prev_q;
	logic                            prev_ok_q;
	logic [ADDR_W-1:0]               node_q;
	bct_pkg::bct_status_t            st_q;

	bct_pkg::bct_mem_ctl_t           ctl;
	logic [ADDR_W-1:0]               rd_addr;
	logic [ADDR_W-1:0]               kp_addr;
	logic [KEY_BITS-1:0]             kp_key;
	logic [bct_pkg::PAYLOAD_W-1:0]   kp_pay;
	logic [ADDR_W-1:0]               lk_addr;
	logic [LINK_W-1:0]               lk_data;
	logic [KEY_BITS-1:0]             rd_key;
	logic [bct_pkg::PAYLOAD_W-1:0]   rd_pay;
	logic [LINK_W-1:0]               rd_link;

	logic                            accept;
	logic                            out_free;
	logic [ADDR_W-1:0]               home_addr;
	logic                            home_used;
	logic                            link_null;
	logic [ADDR_W-1:0]               rd_next;
	logic                            hit;
	logic                            free_null;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	assign home_addr = ADDR_W'(home_q);
	assign home_used = used_q[home_q[HU_W-1:0]];
	assign link_null = (rd_link == NULL_LINK);
	assign rd_next   = rd_link[ADDR_W-1:0];
	assign hit       = (rd_key == key_q);
	assign free_null = (free_head_q == NULL_LINK);

	bct_store #(
		.POOL_SLOTS   (POOL_SLOTS),
		.HOME_BUCKETS (HOME_BUCKETS),
		.KEY_BITS     (KEY_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.kp_addr (kp_addr),
		.kp_key  (kp_key),
		.kp_pay  (kp_pay),
		.lk_addr (lk_addr),
		.lk_data (lk_data),
		.rd_key  (rd_key),
		.rd_pay  (rd_pay),
		.rd_link (rd_link)
	);

	// Memory strobes per state
	always_comb begin
		ctl     = '0;
		rd_addr = home_addr;
		kp_addr = home_addr;
		kp_key  = key_q;
		kp_pay  = pay_q;
		lk_addr = home_addr;
		lk_data = NULL_LINK;
		unique case (state_q)
			S_START: begin
				if (known_q && (op_q == bct_pkg::OP_INSERT)) begin
					if (!home_used) begin
						ctl.kp_wr = 1'b1;
						ctl.lk_wr = 1'b1;
					end else if (!free_null) begin
						ctl.rd  = 1'b1;
						rd_addr = free_head_q[ADDR_W-1:0];
					end
				end else if (known_q && home_used &&
						((op_q == bct_pkg::OP_DELETE) || (op_q == bct_pkg::OP_SEARCH))) begin
					ctl.rd = 1'b1;
				end
			end
			S_ALLOC: begin
				ctl.kp_wr = 1'b1;
				kp_addr   = node_q;
				ctl.lk_wr = 1'b1;
				lk_addr   = node_q;
				ctl.rd    = 1'b1;
			end
			S_TAIL: begin
				if (link_null) begin
					ctl.lk_wr = 1'b1;
					lk_addr   = cur_q;
					lk_data   = LINK_W'(node_q);
				end else begin
					ctl.rd  = 1'b1;
					rd_addr = rd_next;
				end
			end
			S_CMP: begin
				if (hit && (op_q == bct_pkg::OP_DELETE) && prev_ok_q) begin
					// unlink: predecessor skips the matched node
					ctl.lk_wr = 1'b1;
					lk_addr   = prev_q;
					lk_data   = rd_link;
				end else if (!link_null &&
						(!hit || ((op_q == bct_pkg::OP_DELETE) && !prev_ok_q))) begin
					ctl.rd  = 1'b1;
					rd_addr = rd_next;
				end
			end
			S_PROMOTE: begin
				ctl.kp_wr = 1'b1;
				kp_key    = rd_key;
				kp_pay    = rd_pay;
				ctl.lk_wr = 1'b1;
				lk_data   = rd_link;
			end
			S_FREE: begin
				ctl.lk_wr = 1'b1;
				lk_addr   = cur_q;
				lk_data   = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, home marks, free list head and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			free_head_q <= LINK_W'(HOME_BUCKETS);
			out_valid_q <= 1'b0;
			status_q    <= bct_pkg::ST_DONE;
		end else begin
			// a finishing request reloads the register in the same cycle
			if (out_valid_q && !out_stall && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					priority if (op_q == bct_pkg::OP_NONE || !known_q) begin
						state_q <= S_FINISH;
					end else if (op_q == bct_pkg::OP_INSERT) begin
						if (!home_used) begin
							used_q[home_q[HU_W-1:0]] <= 1'b1;
							state_q <= S_FINISH;
						end else if (free_null) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_ALLOC;
						end
					end else if (!home_used) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_ALLOC: begin
					free_head_q <= rd_link;
					state_q     <= S_TAIL;
				end
				S_TAIL: begin
					if (link_null) begin
						state_q <= S_FINISH;
					end
				end
				S_CMP: begin
					if (hit) begin
						priority if (op_q == bct_pkg::OP_SEARCH) begin
							state_q <= S_FINISH;
						end else if (prev_ok_q) begin
							state_q <= S_FREE;
						end else if (!link_null) begin
							state_q <= S_PROMOTE;
						end else begin
							// lone home entry: mark deleted
							used_q[home_q[HU_W-1:0]] <= 1'b0;
							state_q <= S_FINISH;
						end
					end else if (link_null) begin
						state_q <= S_FINISH;
					end
				end
				S_PROMOTE: begin
					state_q <= S_FREE;
				end
				S_FREE: begin
					free_head_q <= LINK_W'(cur_q);
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request hold, walk pointers and pending status
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= bct_pkg::bct_op_t'(opcode);
					known_q <= bucket_known && (32'(bucket_index) < HOME_BUCKETS);
					home_q  <= bucket_index;
					key_q   <= entry_key[KEY_BITS-1:0];
					pay_q   <= entry_payload;
				end
			end
			S_START: begin
				cur_q     <= home_addr;
				prev_ok_q <= 1'b0;
				node_q    <= free_head_q[ADDR_W-1:0];
				priority if (op_q == bct_pkg::OP_NONE) begin
					st_q <= bct_pkg::ST_DONE;
				end else if (!known_q) begin
					st_q <= bct_pkg::ST_UNKNOWN;
				end else if (op_q == bct_pkg::OP_INSERT) begin
					st_q <= (home_used && free_null) ? bct_pkg::ST_DROPPED : bct_pkg::ST_DONE;
				end else begin
					st_q <= bct_pkg::ST_MISSING;
				end
			end
			S_ALLOC: begin
				cur_q <= home_addr;
			end
			S_TAIL: begin
				if (!link_null) begin
					cur_q <= rd_next;
				end
			end
			S_CMP: begin
				if (hit) begin
					st_q <= (op_q == bct_pkg::OP_SEARCH) ? bct_pkg::ST_FOUND : bct_pkg::ST_DONE;
					if (!prev_ok_q && !link_null) begin
						cur_q <= rd_next;
					end
				end else if (!link_null) begin
					prev_q    <= cur_q;
					prev_ok_q <= 1'b1;
					cur_q     <= rd_next;
				end
			end
			default: begin
			end
		endcase
	end

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NULL_LINK) || (free_head_q >= LINK_W'(HOME_BUCKETS)))
		else $error("free list head points at a home slot");

	a_finish_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished request did not post its status");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_START && !$stable(in_stall) && !out_valid_q) ||
			(state_q == S_START))
		else $error("accepted request did not start");

	a_walk_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && !hit && !link_null) |-> ctl.rd && !ctl.lk_wr && !ctl.kp_wr)
		else $error("chain walk step issued no read");

endmodule

// ===== design/bct_ram.sv =====
// -----------------------------------------------------------------------------
// bct_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. A read and write of the same address in one cycle returns
// the old contents.
// -----------------------------------------------------------------------------
module bct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bct_store.sv =====
// -----------------------------------------------------------------------------
// bct_store
// Slot store: key, payload and link RAMs plus the fresh-node watermark.
// Overflow slots at or above the watermark have never been handed out, so
// their link still reads as the next slot (or null for the last one).
// -----------------------------------------------------------------------------
module bct_store #(
	parameter int unsigned POOL_SLOTS   = 64,
	parameter int unsigned HOME_BUCKETS = 16,
	parameter int unsigned KEY_BITS     = 64,
	localparam int unsigned ADDR_W      = $clog2(POOL_SLOTS),
	localparam int unsigned LINK_W      = $clog2(POOL_SLOTS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bct_pkg::bct_mem_ctl_t            ctl,
	input  logic [ADDR_W-1:0]                rd_addr,
	input  logic [ADDR_W-1:0]                kp_addr,
	input  logic [KEY_BITS-1:0]              kp_key,
	input  logic [bct_pkg::PAYLOAD_W-1:0]    kp_pay,
	input  logic [ADDR_W-1:0]                lk_addr,
	input  logic [LINK_W-1:0]                lk_data,
	output logic [KEY_BITS-1:0]              rd_key,
	output logic [bct_pkg::PAYLOAD_W-1:0]    rd_pay,
	output logic [LINK_W-1:0]                rd_link
);

	logic [LINK_W-1:0] wm_q;
	logic              fresh_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [LINK_W-1:0] ram_link;

	bct_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (ctl.kp_wr),
		.waddr (kp_addr),
		.wdata (kp_key),
		.re    (ctl.rd),
		.raddr (rd_addr),
		.rdata (rd_key)
	);

	bct_ram #(.WIDTH(bct_pkg::PAYLOAD_W), .DEPTH(POOL_SLOTS)) u_pay_ram (
		.clk   (clk),
		.we    (ctl.kp_wr),
		.waddr (kp_addr),
		.wdata (kp_pay),
		.re    (ctl.rd),
		.raddr (rd_addr),
		.rdata (rd_pay)
	);

	bct_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (ctl.lk_wr),
		.waddr (lk_addr),
		.wdata (lk_data),
		.re    (ctl.rd),
		.raddr (rd_addr),
		.rdata (ram_link)
	);

	// Fresh slots are taken in ascending order: advance past each first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q <= LINK_W'(HOME_BUCKETS);
		end else if (ctl.lk_wr && (LINK_W'(lk_addr) >= wm_q)) begin
			wm_q <= LINK_W'(lk_addr) + LINK_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			fresh_s1   <= (LINK_W'(rd_addr) >= wm_q);
			rd_addr_s1 <= rd_addr;
		end
	end

	// Last slot plus one is the null code, so one increment covers both cases
	assign rd_link = fresh_s1 ? (LINK_W'(rd_addr_s1) + LINK_W'(1)) : ram_link;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |-> !((ctl.lk_wr && (lk_addr == rd_addr)) ||
			(ctl.kp_wr && (kp_addr == rd_addr))))
		else $error("read and write of the same slot in one cycle");

	a_fresh_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.lk_wr && (LINK_W'(lk_addr) >= wm_q)) |-> (LINK_W'(lk_addr) == wm_q))
		else $error("fresh slot written out of order");

endmodule

// ===== verif/bct_status_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// bct_status_checker
// Watches the request and response channels of the chain table unit. Each
// accepted request word runs through a local model of the home buckets,
// overflow chains and free list; the status it yields is queued and compared
// with the next accepted response word.
// -----------------------------------------------------------------------------
module bct_status_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [bct_pkg::OPCODE_W-1:0]  opcode,
	input  logic                          bucket_known,
	input  logic [bct_pkg::INDEX_W-1:0]   bucket_index,
	input  logic [bct_pkg::KEYPORT_W-1:0] entry_key,
	input  logic [bct_pkg::PAYLOAD_W-1:0] entry_payload,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [bct_pkg::STATUS_W-1:0]  status,
	output int unsigned                   mismatches,
	output int unsigned                   outstanding
);
	import bct_pkg::*;

	localparam int unsigned SLOTS = 64;
	localparam int unsigned HOMES = 16;
	localparam int unsigned NIL   = SLOTS;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	logic [KEYPORT_W-1:0] node_key     [SLOTS];
	logic [PAYLOAD_W-1:0] node_payload [SLOTS];
	int unsigned          node_next    [SLOTS];
	mark_t                bucket_mark  [HOMES];
	int unsigned          free_ptr;

	bct_status_t status_due[$];
	int unsigned fail_total;

	// An empty or deleted home slot never matches
	function automatic bit key_hit(int unsigned s, int unsigned home, logic [KEYPORT_W-1:0] k);
		if (s == home && bucket_mark[home] != MARK_USED)
			return 1'b0;
		return node_key[s] == k;
	endfunction

	function automatic bct_status_t table_update(bct_op_t op, logic known,
			logic [INDEX_W-1:0] idx, logic [KEYPORT_W-1:0] k, logic [PAYLOAD_W-1:0] p);
		int unsigned home, cur, prev, tail, nxt, node, steps;
		if (op == OP_NONE)
			return ST_DONE;
		if (!known || idx >= HOMES)
			return ST_UNKNOWN;
		home = idx;
		cur  = home;
		prev = NIL;
		case (op)
			OP_INSERT: begin
				if (bucket_mark[home] != MARK_USED) begin
					node_key[home]     = k;
					node_payload[home] = p;
					node_next[home]    = NIL;
					bucket_mark[home]  = MARK_USED;
					return ST_DONE;
				end
				if (free_ptr >= SLOTS)
					return ST_DROPPED;
				node               = free_ptr;
				free_ptr           = node_next[node];
				node_key[node]     = k;
				node_payload[node] = p;
				node_next[node]    = NIL;
				tail = home;
				for (steps = 0; steps < SLOTS && node_next[tail] < SLOTS; steps++)
					tail = node_next[tail];
				node_next[tail] = node;
				return ST_DONE;
			end
			OP_DELETE: begin
				for (steps = 0; steps < SLOTS && cur < SLOTS; steps++) begin
					if (key_hit(cur, home, k)) begin
						if (cur == home) begin
							nxt = node_next[home];
							if (nxt < SLOTS) begin
								// promote the second node, recycle it
								node_key[home]     = node_key[nxt];
								node_payload[home] = node_payload[nxt];
								node_next[home]    = node_next[nxt];
								node_next[nxt]     = free_ptr;
								free_ptr           = nxt;
							end else begin
								bucket_mark[home] = MARK_DELETED;
							end
						end else if (prev < SLOTS) begin
							node_next[prev] = node_next[cur];
							node_next[cur]  = free_ptr;
							free_ptr        = cur;
						end
						return ST_DONE;
					end
					prev = cur;
					cur  = node_next[cur];
				end
				return ST_MISSING;
			end
			default: begin
				for (steps = 0; steps < SLOTS && cur < SLOTS; steps++) begin
					if (key_hit(cur, home, k))
						return ST_FOUND;
					cur = node_next[cur];
				end
				return ST_MISSING;
			end
		endcase
		return ST_MISSING;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int unsigned i;
		bct_status_t due;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++)
				node_next[i] = (i < HOMES || i + 1 >= SLOTS) ? NIL : i + 1;
			for (i = 0; i < HOMES; i++)
				bucket_mark[i] = MARK_EMPTY;
			free_ptr = HOMES;
			status_due.delete();
			fail_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: status word with none expected, expected none, actual %0d",
						$time, status);
					fail_total++;
				end else begin
					due = status_due.pop_front();
					if (status !== due) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, due, status);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(table_update(bct_op_t'(opcode), bucket_known,
					bucket_index, entry_key, entry_payload));
			mismatches  <= fail_total;
			outstanding <= status_due.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bucketed chain table unit. A short directed
// run covers chain promotion, unlink, deleted homes and ignored requests;
// random phases then load the pool with inserts, drain it and mix all
// operations, with random gaps on both channels and one long output hold.
// -----------------------------------------------------------------------------
module tb_top;
	import bct_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 630;
	localparam int unsigned KEY_SET        = 16;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned HOLD_AFTER     = 120;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 100;

	typedef enum int {
		MIX_PHASE   = 0,
		FILL_PHASE  = 1,
		DRAIN_PHASE = 2
	} phase_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [OPCODE_W-1:0]  opcode;
	logic                 bucket_known;
	logic [INDEX_W-1:0]   bucket_index;
	logic [KEYPORT_W-1:0] entry_key;
	logic [PAYLOAD_W-1:0] entry_payload;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;

	int unsigned          check_fails;
	int unsigned          status_pending;
	int unsigned          idle_cycles;
	logic [KEYPORT_W-1:0] key_set [KEY_SET];
	bit                   sender_calm;

	bucketed_chain_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.bucket_known  (bucket_known),
		.bucket_index  (bucket_index),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status)
	);

	bct_status_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.bucket_known  (bucket_known),
		.bucket_index  (bucket_index),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.mismatches    (check_fails),
		.outstanding   (status_pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned next_gap();
		int unsigned r;
		if (sender_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request word and hold it until taken
	task automatic send_word(bct_op_t op, logic known, logic [INDEX_W-1:0] idx,
			logic [KEYPORT_W-1:0] k, logic [PAYLOAD_W-1:0] p);
		int unsigned gap;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode        <= op;
		bucket_known  <= known;
		bucket_index  <= idx;
		entry_key     <= k;
		entry_payload <= p;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_pending != 0);
	endtask

	task automatic random_word(phase_t kind, int unsigned focus);
		int unsigned r;
		bct_op_t op;
		logic known;
		logic [INDEX_W-1:0] idx;
		logic [KEYPORT_W-1:0] k;
		r = $urandom_range(0, 99);
		case (kind)
			FILL_PHASE: begin
				if (r < 85)      op = OP_INSERT;
				else if (r < 91) op = OP_SEARCH;
				else if (r < 96) op = OP_DELETE;
				else             op = OP_NONE;
			end
			DRAIN_PHASE: begin
				if (r < 65)      op = OP_DELETE;
				else if (r < 85) op = OP_SEARCH;
				else if (r < 96) op = OP_INSERT;
				else             op = OP_NONE;
			end
			default: begin
				if (r < 40)      op = OP_INSERT;
				else if (r < 70) op = OP_DELETE;
				else if (r < 96) op = OP_SEARCH;
				else             op = OP_NONE;
			end
		endcase
		known = ($urandom_range(0, 99) >= 3);
		// crowd most words onto a few buckets so chains grow long
		if ($urandom_range(0, 99) < 65)
			idx = INDEX_W'(focus + $urandom_range(0, 2));
		else
			idx = INDEX_W'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 85)
			k = key_set[$urandom_range(0, KEY_SET - 1)];
		else
			k = {$urandom, $urandom};
		send_word(op, known, idx, k, {$urandom, $urandom});
	endtask

	// Response side: random stalls, calm stretches and one long hold
	initial begin : receiver
		int unsigned stall_left, calm_left, took, r;
		bit held;
		stall_left = 0;
		calm_left  = 0;
		took       = 0;
		held       = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				took++;
			if (!held && took >= HOLD_AFTER) begin
				held       = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (calm_left != 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					calm_left = $urandom_range(30, 120);
					out_stall <= 1'b0;
				end else if (r < 20) begin
					stall_left = $urandom_range(0, 2);
					out_stall <= 1'b1;
				end else if (r < 23) begin
					stall_left = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned done_items, phase_len, n, focus;
		phase_t kind;
		idle_cycles    = 0;
		sender_calm    = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		opcode        <= OP_INSERT;
		bucket_known  <= 1'b0;
		bucket_index  <= '0;
		entry_key     <= '0;
		entry_payload <= '0;
		foreach (key_set[i])
			key_set[i] = {$urandom, $urandom};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty home holds a zero key yet must not match
		send_word(OP_SEARCH, 1'b1, 4'd0, '0, '0);
		send_word(OP_DELETE, 1'b1, 4'd0, '0, '0);
		send_word(OP_INSERT, 1'b1, 4'd0, '1, '0);
		send_word(OP_INSERT, 1'b1, 4'd0, '0, '1);
		send_word(OP_INSERT, 1'b1, 4'd0, '1, '1);
		send_word(OP_SEARCH, 1'b1, 4'd0, '0, '0);
		// unlink chain node, then promote second node into home
		send_word(OP_DELETE, 1'b1, 4'd0, '0, '0);
		send_word(OP_DELETE, 1'b1, 4'd0, '1, '0);
		send_word(OP_SEARCH, 1'b1, 4'd0, '1, '0);
		// lone home entry goes to deleted, then refills
		send_word(OP_DELETE, 1'b1, 4'd0, '1, '0);
		send_word(OP_SEARCH, 1'b1, 4'd0, '1, '0);
		send_word(OP_DELETE, 1'b1, 4'd0, '1, '0);
		send_word(OP_INSERT, 1'b1, 4'd0, 64'd5, '1);
		send_word(OP_NONE,   1'b1, 4'd15, '1, '1);
		send_word(OP_NONE,   1'b0, 4'd0, '0, '0);
		send_word(OP_INSERT, 1'b0, 4'd15, '1, '1);
		send_word(OP_SEARCH, 1'b0, 4'd15, '1, '0);
		send_word(OP_INSERT, 1'b1, 4'd15, '1, '1);
		send_word(OP_SEARCH, 1'b1, 4'd15, '1, '0);
		send_word(OP_DELETE, 1'b1, 4'd15, '0, '0);
		wait_empty();

		done_items = 0;
		kind       = FILL_PHASE;
		focus      = $urandom_range(0, 15);
		while (done_items < RANDOM_ITEMS) begin
			phase_len   = (kind == FILL_PHASE) ? $urandom_range(70, 100) : $urandom_range(30, 80);
			sender_calm = ($urandom_range(0, 3) == 0);
			for (n = 0; n < phase_len && done_items < RANDOM_ITEMS; n++) begin
				random_word(kind, focus);
				done_items++;
			end
			// pause until every status word is back
			wait_empty();
			kind = phase_t'($urandom_range(0, 2));
			if ($urandom_range(0, 1) != 0)
				focus = $urandom_range(0, 15);
		end
		sender_calm = 1'b0;

		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_fails == 0 && status_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== bucketed_chain_table_unit.f =====
design/bct_pkg.sv
design/bct_ram.sv
design/bct_store.sv
design/bucketed_chain_table_unit.sv
verif/bct_status_checker.sv
verif/tb_top.sv
